FILE: hdl/ikht_pkg.sv
`default_nettype none
package ikht_pkg;

  localparam int KEY_W  = 31;
  localparam int VAL_W  = 32;
  localparam int OP_W   = 2;
  localparam int STAT_W = 2;
  localparam int CFG_W  = 9;

  typedef enum logic [OP_W-1:0] {
    OP_LOOKUP = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK      = 2'd0,
    STAT_MISSING = 2'd1,
    STAT_PRESENT = 2'd2,
    STAT_FULL    = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DIV,
    S_READ,
    S_LOOK,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic [KEY_W-1:0] key;
    logic             valid;
  } slot_t;

  localparam int SLOT_W = $bits(slot_t);

endpackage
`default_nettype wire

FILE: hdl/ikht_ram.sv
`default_nettype none
module ikht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                  clk,
  input  wire logic                  we,
  input  wire logic [AW-1:0]         waddr,
  input  wire logic [WIDTH-1:0]      wdata,
  input  wire logic                  re,
  input  wire logic [AW-1:0]         raddr,
  output      logic [WIDTH-1:0]      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

FILE: hdl/int_key_hash_table_core.sv
// an accepted input beat runs through 31 remainder steps, one bucket read, one read-modify-write
//   and a result load, which waits while the output still holds an untaken result beat
// one beat in flight at a time, set by the bit-serial modulo and the single RAM port
// reset: a clearing pass zeroes every bucket row; in_tready stays low meanwhile
// bucket_count resets to 256 and may be written during the pass
`default_nettype none
module int_key_hash_table_core #(
  parameter int BUCKETS = 256,
  parameter int WAYS    = 4
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [8:0]  cfg_wdata,
  input  wire logic        in_tvalid,
  output      logic        in_tready,
  input  wire logic [63:0] in_tdata,   // key [30:0], value [62:31], zero [63]
  input  wire logic [1:0]  in_tuser,   // operation [1:0]
  output      logic        out_tvalid,
  input  wire logic        out_tready,
  output      logic [31:0] out_tdata,  // value_out [31:0]
  output      logic [1:0]  out_tuser   // status [1:0]
);

  localparam int BW    = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int WW    = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int ROW_W = WAYS * ikht_pkg::SLOT_W;
  localparam int CW    = ikht_pkg::CFG_W;
  localparam logic [CW:0] BMAX = (BUCKETS > 511) ? (CW+1)'(511) : (CW+1)'(BUCKETS);
  localparam logic [BW-1:0] LAST_ROW = BW'(BUCKETS - 1);
  localparam logic [4:0] LAST_STEP = 5'(ikht_pkg::KEY_W - 1);

  ikht_pkg::state_t state_r, state_nxt;

  logic [CW-1:0]               cfg_r;
  logic [CW-1:0]               div_r, div_nxt;
  logic [CW-1:0]               rem_r, rem_nxt;
  logic [ikht_pkg::KEY_W-1:0]  sh_r, sh_nxt;
  logic [4:0]                  cnt_r, cnt_nxt;
  logic [BW-1:0]               clr_r, clr_nxt;
  ikht_pkg::op_t               op_r;
  logic [ikht_pkg::KEY_W-1:0]  key_r;
  logic [ikht_pkg::VAL_W-1:0]  val_r;
  ikht_pkg::status_t           res_status_r, res_status_nxt;
  logic [ikht_pkg::VAL_W-1:0]  res_value_r, res_value_nxt;
  logic                        out_valid_r, out_valid_nxt;
  ikht_pkg::status_t           out_status_r;
  logic [ikht_pkg::VAL_W-1:0]  out_value_r;

  logic                        accept;
  logic                        load_out;
  logic [CW-1:0]               eff_n;
  logic [CW:0]                 rem_sh;

  logic                        mem_we, mem_re;
  logic [BW-1:0]               mem_waddr;
  logic [ROW_W-1:0]            mem_wdata, mem_rdata;
  ikht_pkg::slot_t [WAYS-1:0]  rd_row, wr_row;
  logic [WAYS-1:0]             hit, free;
  logic                        any_hit, any_free;
  logic [WW-1:0]               hit_way, free_way;

  assign accept   = in_tvalid && in_tready;
  assign rd_row   = mem_rdata;

  always_comb begin
    if (cfg_r == '0) begin
      eff_n = CW'(1);
    end else if ({1'b0, cfg_r} > BMAX) begin
      eff_n = CW'(BMAX);
    end else begin
      eff_n = cfg_r;
    end
  end

  assign rem_sh = {rem_r, sh_r[ikht_pkg::KEY_W-1]};

  always_comb begin
    hit_way  = '0;
    free_way = '0;
    any_hit  = 1'b0;
    any_free = 1'b0;
    for (int w = 0; w < WAYS; w++) begin
      hit[w]  = rd_row[w].valid && (rd_row[w].key == key_r);
      free[w] = !rd_row[w].valid;
    end
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (hit[w]) begin
        hit_way = WW'(w);
        any_hit = 1'b1;
      end
      if (free[w]) begin
        free_way = WW'(w);
        any_free = 1'b1;
      end
    end
  end

  always_comb begin
    state_nxt      = state_r;
    div_nxt        = div_r;
    rem_nxt        = rem_r;
    sh_nxt         = sh_r;
    cnt_nxt        = cnt_r;
    clr_nxt        = clr_r;
    res_status_nxt = res_status_r;
    res_value_nxt  = res_value_r;
    in_tready      = 1'b0;
    mem_we         = 1'b0;
    mem_re         = 1'b0;
    mem_waddr      = BW'(rem_r);
    wr_row         = rd_row;
    load_out       = 1'b0;
    unique case (state_r)
      ikht_pkg::S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        wr_row    = '0;
        clr_nxt   = clr_r + BW'(1);
        if (clr_r == LAST_ROW) begin
          state_nxt = ikht_pkg::S_IDLE;
        end
      end
      ikht_pkg::S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          div_nxt   = eff_n;
          rem_nxt   = '0;
          sh_nxt    = in_tdata[ikht_pkg::KEY_W-1:0];
          cnt_nxt   = '0;
          state_nxt = ikht_pkg::S_DIV;
        end
      end
      ikht_pkg::S_DIV: begin
        if (rem_sh >= {1'b0, div_r}) begin
          rem_nxt = CW'(rem_sh - {1'b0, div_r});
        end else begin
          rem_nxt = CW'(rem_sh);
        end
        sh_nxt  = {sh_r[ikht_pkg::KEY_W-2:0], 1'b0};
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == LAST_STEP) begin
          state_nxt = ikht_pkg::S_READ;
        end
      end
      ikht_pkg::S_READ: begin
        mem_re    = 1'b1;
        state_nxt = ikht_pkg::S_LOOK;
      end
      ikht_pkg::S_LOOK: begin
        res_status_nxt = ikht_pkg::STAT_MISSING;
        res_value_nxt  = '0;
        case (op_r)
          ikht_pkg::OP_LOOKUP: begin
            if (any_hit) begin
              res_status_nxt = ikht_pkg::STAT_OK;
              res_value_nxt  = rd_row[hit_way].value;
            end
          end
          ikht_pkg::OP_INSERT: begin
            if (any_hit) begin
              res_status_nxt = ikht_pkg::STAT_PRESENT;
            end else if (any_free) begin
              res_status_nxt           = ikht_pkg::STAT_OK;
              wr_row[free_way].valid   = 1'b1;
              wr_row[free_way].key     = key_r;
              wr_row[free_way].value   = val_r;
              mem_we                   = 1'b1;
            end else begin
              res_status_nxt = ikht_pkg::STAT_FULL;
            end
          end
          ikht_pkg::OP_DELETE: begin
            if (any_hit) begin
              res_status_nxt        = ikht_pkg::STAT_OK;
              res_value_nxt         = rd_row[hit_way].value;
              wr_row[hit_way].valid = 1'b0;
              mem_we                = 1'b1;
            end
          end
          default: begin
          end
        endcase
        state_nxt = ikht_pkg::S_DONE;
      end
      ikht_pkg::S_DONE: begin
        if (!out_valid_r || out_tready) begin
          load_out  = 1'b1;
          state_nxt = ikht_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = ikht_pkg::S_IDLE;
      end
    endcase
  end

  assign mem_wdata = wr_row;

  always_comb begin
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ikht_pkg::S_CLEAR;
      clr_r       <= '0;
      cfg_r       <= CW'(256);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        cfg_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    div_r        <= div_nxt;
    rem_r        <= rem_nxt;
    sh_r         <= sh_nxt;
    cnt_r        <= cnt_nxt;
    res_status_r <= res_status_nxt;
    res_value_r  <= res_value_nxt;
    if (accept) begin
      op_r  <= ikht_pkg::op_t'(in_tuser);
      key_r <= in_tdata[ikht_pkg::KEY_W-1:0];
      val_r <= in_tdata[ikht_pkg::KEY_W +: ikht_pkg::VAL_W];
    end
    if (load_out) begin
      out_status_r <= res_status_r;
      out_value_r  <= res_value_r;
    end
  end

  ikht_ram #(
    .WIDTH (ROW_W),
    .DEPTH (BUCKETS)
  ) u_rows (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (BW'(rem_r)),
    .rdata (mem_rdata)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_value_r;
  assign out_tuser  = out_status_r;

`ifndef SYNTHESIS
  a_zero_value_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != ikht_pkg::STAT_OK) |-> (out_tdata == '0))
    else $error("nonzero value with failing status");

  a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ikht_pkg::S_DIV) |-> (rem_r < div_r))
    else $error("partial remainder not below divisor");

  a_accept_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == ikht_pkg::S_DIV) && (cnt_r == '0))
    else $error("accepted beat did not start remainder");

  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ikht_pkg::S_IDLE || state_r == ikht_pkg::S_DIV) |-> !mem_we)
    else $error("row write outside clear or update");

  a_bucket_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    mem_re |-> ({1'b0, rem_r} < BMAX))
    else $error("bucket index out of range");
`endif

endmodule
`default_nettype wire

FILE: tb/tb_int_key_hash_table_core.sv
`timescale 1ns / 100ps
`default_nettype none
module tb_int_key_hash_table_core;

  localparam int BUCKETS    = 256;
  localparam int WAYS       = 4;
  localparam int SLOTS      = BUCKETS * WAYS;
  localparam int IDLE_LIMIT = 3000;
  localparam int LONG_HOLD  = 400;
  localparam int PHASE_LEN  = 145;

  typedef struct {
    ikht_pkg::op_t     op;
    bit [30:0]         key;
    ikht_pkg::status_t status;
    bit [31:0]         value;
  } map_result_t;

  class hash_map_scoreboard;
    bit          slot_used [SLOTS];
    bit [30:0]   slot_key  [SLOTS];
    bit [31:0]   slot_val  [SLOTS];
    bit [8:0]    bucket_reg;
    map_result_t expected_q[$];
    int          errors;
    int          ops_seen;
    int          status_hits[4];

    function new();
      foreach (slot_used[i]) slot_used[i] = 1'b0;
      bucket_reg = 9'd256;
      errors     = 0;
      ops_seen   = 0;
      foreach (status_hits[i]) status_hits[i] = 0;
    endfunction

    function void set_buckets(bit [8:0] v);
      bucket_reg = v;
    endfunction

    function int unsigned active_buckets();
      int unsigned n;
      n = bucket_reg;
      if (n == 0) n = 1;
      if (n > BUCKETS) n = BUCKETS;
      return n;
    endfunction

    function void note_input(ikht_pkg::op_t op, bit [30:0] key, bit [31:0] val);
      map_result_t exp;
      int unsigned base;
      int          hit_way;
      base       = (key % active_buckets()) * WAYS;
      hit_way    = -1;
      exp.op     = op;
      exp.key    = key;
      exp.status = ikht_pkg::STAT_MISSING;
      exp.value  = '0;
      for (int w = WAYS - 1; w >= 0; w--)
        if (slot_used[base + w] && slot_key[base + w] == key) hit_way = w;
      case (op)
        ikht_pkg::OP_LOOKUP: begin
          if (hit_way >= 0) begin
            exp.status = ikht_pkg::STAT_OK;
            exp.value  = slot_val[base + hit_way];
          end
        end
        ikht_pkg::OP_INSERT: begin
          if (hit_way >= 0) begin
            exp.status = ikht_pkg::STAT_PRESENT;
          end else begin
            exp.status = ikht_pkg::STAT_FULL;
            for (int w = 0; w < WAYS; w++) begin
              if (exp.status == ikht_pkg::STAT_FULL && !slot_used[base + w]) begin
                slot_used[base + w] = 1'b1;
                slot_key[base + w]  = key;
                slot_val[base + w]  = val;
                exp.status          = ikht_pkg::STAT_OK;
              end
            end
          end
        end
        ikht_pkg::OP_DELETE: begin
          if (hit_way >= 0) begin
            exp.status                = ikht_pkg::STAT_OK;
            exp.value                 = slot_val[base + hit_way];
            slot_used[base + hit_way] = 1'b0;
          end
        end
        default: ;
      endcase
      expected_q.push_back(exp);
    endfunction

    function void check_result(ikht_pkg::status_t status, bit [31:0] value);
      map_result_t exp;
      ops_seen++;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: result beat with nothing pending, status %s value %h",
                   status.name(), value);
        return;
      end
      exp = expected_q.pop_front();
      status_hits[exp.status]++;
      if (status !== exp.status || value !== exp.value) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: %s key %h expected %s/%h got %s/%h", exp.op.name(),
                   exp.key, exp.status.name(), exp.value, status.name(), value);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [8:0]  cfg_wdata;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;
  logic [1:0]  out_tuser;

  hash_map_scoreboard map_sb;
  int                 burst_left;
  int                 idle_cycles = 0;
  int                 results_seen;
  int                 settings_used;

  int_key_hash_table_core #(
    .BUCKETS (BUCKETS),
    .WAYS    (WAYS)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  task automatic send_op(ikht_pkg::op_t op, bit [30:0] key, bit [31:0] val);
    int gap;
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {1'b0, val, key};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    map_sb.note_input(op, key, val);
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 45) : $urandom_range(1, 8);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(0, 12);
    end else begin
      burst_left--;
    end
  endtask

  task automatic drain_map();
    in_tvalid <= 1'b0;
    while (map_sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_buckets(bit [8:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    map_sb.set_buckets(v);
    @(posedge clk);
    cfg_we    <= 1'b0;
    settings_used++;
  endtask

  function automatic bit [30:0] pick_key(int unsigned nb);
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 31'($urandom_range(0, 3) + nb * $urandom_range(0, 7));
    if (r < 80) return 31'($urandom_range(0, 255));
    if (r < 90) return 31'h7FFF_FFFF - 31'($urandom_range(0, 15));
    return 31'($urandom);
  endfunction

  function automatic bit [31:0] pick_value();
    case ($urandom_range(0, 15))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic ikht_pkg::op_t pick_op();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return ikht_pkg::OP_INSERT;
    if (r < 70) return ikht_pkg::OP_LOOKUP;
    if (r < 95) return ikht_pkg::OP_DELETE;
    return ikht_pkg::OP_NONE;
  endfunction

  // receiver: checks result beats and stalls on its own pattern
  initial begin
    int stall_left;
    int long_left;
    int rx_cycle;
    stall_left   = 0;
    long_left    = 0;
    rx_cycle     = 0;
    results_seen = 0;
    out_tready   <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        map_sb.check_result(ikht_pkg::status_t'(out_tuser), out_tdata);
        results_seen++;
        if (results_seen == 200 || results_seen == 800) long_left = LONG_HOLD;
      end
      rx_cycle++;
      if (long_left > 0) begin
        out_tready <= 1'b0;
        long_left--;
      end else if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= 1'b1;
        if ((rx_cycle % 4096) >= 1024 && $urandom_range(0, 7) == 0)
          stall_left = $urandom_range(1, 40);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("watchdog: no beat for %0d cycles, %0d results pending", IDLE_LIMIT,
                   map_sb.pending());
          $display("** int_key_hash_table_core: FAILED **");
          $finish;
        end
      end
    end
  end

  initial begin
    bit [8:0] settings[10];
    int       items_sent;
    settings      = '{9'd1, 9'd0, 9'd2, 9'd511, 9'd3, 9'd257, 9'd37, 9'd255, 9'd128, 9'd256};
    map_sb        = new();
    burst_left    = 0;
    settings_used = 0;
    items_sent    = 0;
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    in_tuser      = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed part at the reset bucket count
    send_op(ikht_pkg::OP_LOOKUP, 31'd0, 32'h1111_1111);
    send_op(ikht_pkg::OP_INSERT, 31'd0, 32'h0000_0000);
    send_op(ikht_pkg::OP_INSERT, 31'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_op(ikht_pkg::OP_LOOKUP, 31'h7FFF_FFFF, 32'h0);
    send_op(ikht_pkg::OP_LOOKUP, 31'd0, 32'h0);
    send_op(ikht_pkg::OP_INSERT, 31'd0, 32'h0000_1234);
    send_op(ikht_pkg::OP_INSERT, 31'd256, 32'hA5A5_A5A5);
    send_op(ikht_pkg::OP_INSERT, 31'd512, 32'h8000_0001);
    send_op(ikht_pkg::OP_INSERT, 31'd768, 32'h7FFF_FFFE);
    send_op(ikht_pkg::OP_INSERT, 31'd1024, 32'hDEAD_BEEF);
    send_op(ikht_pkg::OP_DELETE, 31'd512, 32'h0);
    send_op(ikht_pkg::OP_INSERT, 31'd1024, 32'h5A5A_5A5A);
    send_op(ikht_pkg::OP_LOOKUP, 31'd1024, 32'h0);
    send_op(ikht_pkg::OP_DELETE, 31'd512, 32'h0);
    send_op(ikht_pkg::OP_LOOKUP, 31'd512, 32'h0);
    send_op(ikht_pkg::OP_NONE, 31'd0, 32'h0);
    send_op(ikht_pkg::OP_NONE, 31'd1024, 32'hFFFF_FFFF);
    send_op(ikht_pkg::OP_DELETE, 31'h7FFF_FFFF, 32'h0);
    send_op(ikht_pkg::OP_DELETE, 31'd0, 32'h0);
    send_op(ikht_pkg::OP_LOOKUP, 31'd256, 32'h0);
    send_op(ikht_pkg::OP_LOOKUP, 31'h7FFF_FFFF, 32'h0);
    drain_map();

    // random phases; stored entries survive each bucket count change
    foreach (settings[p]) begin
      write_buckets(settings[p]);
      repeat (PHASE_LEN) begin
        send_op(pick_op(), pick_key(map_sb.active_buckets()), pick_value());
        items_sent++;
      end
      drain_map();
    end

    repeat (40) @(posedge clk);
    $display("covered %0d map operations (%0d random) over %0d bucket count settings",
             map_sb.ops_seen, items_sent, settings_used + 1);
    $display("outcomes: ok %0d, missing %0d, present %0d, full %0d; mismatches %0d",
             map_sb.status_hits[ikht_pkg::STAT_OK], map_sb.status_hits[ikht_pkg::STAT_MISSING],
             map_sb.status_hits[ikht_pkg::STAT_PRESENT], map_sb.status_hits[ikht_pkg::STAT_FULL],
             map_sb.errors);
    if (map_sb.errors == 0) begin
      $display("** int_key_hash_table_core: PASSED **");
    end else begin
      $display("** int_key_hash_table_core: FAILED **");
    end
    $finish;
  end

endmodule
`default_nettype wire
